@@ src/async_hdlc_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// async_hdlc_deframer assertion macros
// Shorthand for the concurrent checks in the deframer top level.
// ----------------------------------------------------------------------------
`ifndef ASYNC_HDLC_DEFRAMER_MACROS_SVH
`define ASYNC_HDLC_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AHD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AHD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/ahd_pkg.sv @@
// ----------------------------------------------------------------------------
// ahd_pkg
// Shared types and constants of the async HDLC deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ahd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = CMDQ_AW + 1;

    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = RESQ_AW + 1;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_FLAG = 2'd1,
        CMD_ESC  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_NOSYNC = 3'd0,
        MODE_START  = 3'd1,
        MODE_DATA   = 3'd2,
        MODE_END    = 3'd3,
        MODE_ESC    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_frame;
    } res_t;

    // Up to two results per command; wr1 is only used together with wr0.
    typedef struct packed {
        logic wr0;
        logic wr1;
        res_t res0;
        res_t res1;
    } res_wr_t;

endpackage

`default_nettype wire

@@ src/ahd_front.sv @@
// ----------------------------------------------------------------------------
// ahd_front
// Accepts raw bytes, classifies them and queues them as commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    rx_byte,
    output logic               full,
    output logic               cmd_valid,
    input  wire logic          cmd_take,
    output ahd_pkg::cmd_t      cmd
);

    ahd_pkg::cmd_t                   q_mem [ahd_pkg::CMDQ_DEPTH];
    logic [ahd_pkg::CMDQ_AW-1:0]     wptr_reg, wptr_next;
    logic [ahd_pkg::CMDQ_AW-1:0]     rptr_reg, rptr_next;
    logic [ahd_pkg::CMDQ_CW-1:0]     count_reg, count_next;
    ahd_pkg::cmd_t                   cmd_in;
    logic                            wr_en;
    logic                            rd_en;

    always_comb
    begin
        cmd_in.data = rx_byte;
        case (rx_byte)
            ahd_pkg::FLAG_BYTE: cmd_in.kind = ahd_pkg::CMD_FLAG;
            ahd_pkg::ESC_BYTE:  cmd_in.kind = ahd_pkg::CMD_ESC;
            default:            cmd_in.kind = ahd_pkg::CMD_DATA;
        endcase
    end

    assign full      = (count_reg == ahd_pkg::CMDQ_CW'(ahd_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + ahd_pkg::CMDQ_CW'(wr_en) - ahd_pkg::CMDQ_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ src/ahd_engine.sv @@
// ----------------------------------------------------------------------------
// ahd_engine
// Deframing state machine: unescapes, holds two bytes back, drops empty
// and CR/LF frames, and writes up to two results per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahd_engine
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire ahd_pkg::cmd_t cmd,
    output logic               cmd_take,
    input  wire logic          res_room,
    output ahd_pkg::res_wr_t   res_wr
);

    ahd_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     h0_reg, h0_next;
    logic [7:0]     h1_reg, h1_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           emit_reg, emit_next;
    logic           push_en;
    logic [7:0]     push_val;
    logic           drop;

    // A command is executed only when the result queue can take two entries.
    assign cmd_take = cmd_valid && res_room;

    assign drop = (cnt_reg == 2'd0) ||
                  (!emit_reg && cnt_reg == 2'd2 &&
                   h0_reg == ahd_pkg::CR_BYTE && h1_reg == ahd_pkg::LF_BYTE);

    always_comb
    begin
        mode_next = mode_reg;
        h0_next   = h0_reg;
        h1_next   = h1_reg;
        cnt_next  = cnt_reg;
        emit_next = emit_reg;
        res_wr    = '0;
        push_en   = 1'b0;
        push_val  = cmd.data;

        if (cmd_take)
        begin
            case (cmd.kind)
                ahd_pkg::CMD_FLAG:
                begin
                    case (mode_reg)
                        ahd_pkg::MODE_START, ahd_pkg::MODE_ESC:
                        begin
                        end
                        ahd_pkg::MODE_DATA:
                        begin
                            if (drop)
                            begin
                                mode_next = ahd_pkg::MODE_START;
                            end
                            else
                            begin
                                mode_next = ahd_pkg::MODE_END;
                                res_wr.wr0 = 1'b1;
                                res_wr.res0.frame_byte = h0_reg;
                                if (cnt_reg == 2'd1)
                                begin
                                    res_wr.res0.last_of_frame = 1'b1;
                                end
                                else
                                begin
                                    res_wr.wr1 = 1'b1;
                                    res_wr.res1.frame_byte = h1_reg;
                                    res_wr.res1.last_of_frame = 1'b1;
                                end
                            end
                            cnt_next  = 2'd0;
                            emit_next = 1'b0;
                        end
                        default:
                        begin
                            // no sync, after frame, and stray codes
                            mode_next = ahd_pkg::MODE_START;
                            cnt_next  = 2'd0;
                            emit_next = 1'b0;
                        end
                    endcase
                end
                ahd_pkg::CMD_ESC:
                begin
                    mode_next = ahd_pkg::MODE_ESC;
                end
                ahd_pkg::CMD_DATA:
                begin
                    case (mode_reg)
                        ahd_pkg::MODE_START:
                        begin
                            // new frame: drop any leftover bytes
                            mode_next = ahd_pkg::MODE_DATA;
                            h0_next   = cmd.data;
                            cnt_next  = 2'd1;
                            emit_next = 1'b0;
                        end
                        ahd_pkg::MODE_DATA:
                        begin
                            push_en = 1'b1;
                        end
                        ahd_pkg::MODE_ESC:
                        begin
                            push_en   = 1'b1;
                            push_val  = cmd.data ^ ahd_pkg::ESC_XOR;
                            mode_next = ahd_pkg::MODE_DATA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            if (push_en)
            begin
                if (cnt_reg >= 2'd2)
                begin
                    // window full: oldest byte goes out unmarked
                    res_wr.wr0 = 1'b1;
                    res_wr.res0.frame_byte = h0_reg;
                    res_wr.res0.last_of_frame = 1'b0;
                    h0_next   = h1_reg;
                    h1_next   = push_val;
                    cnt_next  = 2'd2;
                    emit_next = 1'b1;
                end
                else if (cnt_reg == 2'd1)
                begin
                    h1_next  = push_val;
                    cnt_next = 2'd2;
                end
                else
                begin
                    h0_next  = push_val;
                    cnt_next = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ahd_pkg::MODE_NOSYNC;
            cnt_reg  <= 2'd0;
            emit_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            emit_reg <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

endmodule

`default_nettype wire

@@ src/ahd_resq.sv @@
// ----------------------------------------------------------------------------
// ahd_resq
// Result queue: takes up to two results a cycle, gives out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahd_resq
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ahd_pkg::res_wr_t res_wr,
    output logic                  res_room,
    input  wire logic             pop,
    output logic                  empty,
    output logic [7:0]            frame_byte,
    output logic                  last_of_frame
);

    ahd_pkg::res_t                   q_mem [ahd_pkg::RESQ_DEPTH];
    logic [ahd_pkg::RESQ_AW-1:0]     wptr_reg, wptr_next;
    logic [ahd_pkg::RESQ_AW-1:0]     rptr_reg, rptr_next;
    logic [ahd_pkg::RESQ_CW-1:0]     count_reg, count_next;
    logic                            rd_en;
    ahd_pkg::res_t                   head;

    assign empty    = (count_reg == '0);
    assign res_room = (count_reg <= ahd_pkg::RESQ_CW'(ahd_pkg::RESQ_DEPTH - 2));
    assign rd_en    = pop && !empty;

    assign head          = q_mem[rptr_reg];
    assign frame_byte    = head.frame_byte;
    assign last_of_frame = head.last_of_frame;

    always_comb
    begin
        wptr_next  = wptr_reg + ahd_pkg::RESQ_AW'(res_wr.wr0) + ahd_pkg::RESQ_AW'(res_wr.wr1);
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + ahd_pkg::RESQ_CW'(res_wr.wr0)
                   + ahd_pkg::RESQ_CW'(res_wr.wr1) - ahd_pkg::RESQ_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr.wr0)
        begin
            q_mem[wptr_reg] <= res_wr.res0;
        end
        if (res_wr.wr1)
        begin
            q_mem[wptr_reg + 1'b1] <= res_wr.res1;
        end
    end

endmodule

`default_nettype wire

@@ src/async_hdlc_deframer.sv @@
// ----------------------------------------------------------------------------
// async_hdlc_deframer
// Byte-stuffed asynchronous HDLC receiver with CR/LF frame filtering.
// ----------------------------------------------------------------------------
// Takes one raw link byte per cycle (push/full) and gives decoded payload
// bytes out through a queue-style port (empty/pop), with last_of_frame set
// on the byte that precedes the closing flag. 0x7E is the flag, 0x7D escapes
// the next byte (XOR 0x20); empty frames and frames of exactly CR LF are
// dropped. The last two bytes of a frame are held back, so a payload byte
// leaves only once two later bytes or the closing flag have been pushed.
// A pushed byte is written into the 4-entry command queue; the deframing
// engine acts on the queue head and registers its results into the result
// queue.
// The engine runs one command per cycle while the 4-entry result queue has
// room for two entries; the closing flag can write two results, so result
// draining at one per cycle sets the sustained rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "async_hdlc_deframer_macros.svh"

module async_hdlc_deframer
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      frame_byte,
    output logic            last_of_frame
);

    logic              cmd_valid;
    logic              cmd_take;
    ahd_pkg::cmd_t     cmd;
    logic              res_room;
    ahd_pkg::res_wr_t  res_wr;

    ahd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    ahd_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_room  (res_room),
        .res_wr    (res_wr)
    );

    ahd_resq u_resq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_wr        (res_wr),
        .res_room      (res_room),
        .pop           (pop),
        .empty         (empty),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame)
    );

    `AHD_ASSERT_NOW(a_pair_order, res_wr.wr1, res_wr.wr0, "second result without first")
    `AHD_ASSERT_NOW(a_write_needs_take, res_wr.wr0, cmd_take && res_room, "write w/o command")
    `AHD_ASSERT_NEXT(a_write_fills, res_wr.wr0 && !(pop && !empty), !empty, "queue empty")

endmodule

`default_nettype wire

@@ test/async_hdlc_deframer_test.sv @@
// ----------------------------------------------------------------------------
// async_hdlc_deframer_test
// Self-checking bench for the async HDLC deframer.
// ----------------------------------------------------------------------------
// Raw link bytes are queued by the stimulus process and offered by a clocked
// driver. Each accepted byte runs through a deframer model that keeps its own
// mode, held bytes and emit flag and queues the payload bytes it expects.
// A clocked monitor pops results and compares each transaction, field by
// field, against the oldest expected byte. Stimulus is a directed sequence
// followed by random frames (plain, CR LF, escaped, shared flags, broken)
// mixed with line noise, under three idle profiles, one long result stall
// and pauses of the sender until the result side has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module async_hdlc_deframer_test;

    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 620;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       pop   = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] frame_byte;
    logic       last_of_frame;

    // stimulus and scoreboard
    logic [7:0]      raw_bytes_q[$];
    ahd_pkg::res_t   expected_bytes_q[$];
    int              bytes_queued = 0;
    int              bytes_sent   = 0;
    int              errors       = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic            long_hold    = 1'b0;
    int              hold_cycles  = 0;
    int              idle_cycles  = 0;
    ahd_pkg::res_t   oldest;

    // deframer model state
    ahd_pkg::mode_t  rx_mode  = ahd_pkg::MODE_NOSYNC;
    logic [7:0]      held0    = 8'h00;
    logic [7:0]      held1    = 8'h00;
    int              held_num = 0;
    logic            emitted  = 1'b0;

    logic [7:0] directed_bytes[$] = '{
        8'h41, 8'h0D, ahd_pkg::FLAG_BYTE, 8'h00, 8'hFF, ahd_pkg::FLAG_BYTE,
        ahd_pkg::FLAG_BYTE, ahd_pkg::FLAG_BYTE, ahd_pkg::CR_BYTE, ahd_pkg::LF_BYTE,
        ahd_pkg::FLAG_BYTE,
        ahd_pkg::CR_BYTE, ahd_pkg::LF_BYTE, 8'h0B, ahd_pkg::FLAG_BYTE,
        ahd_pkg::ESC_BYTE, 8'h5E, ahd_pkg::FLAG_BYTE,
        ahd_pkg::FLAG_BYTE, ahd_pkg::ESC_BYTE, ahd_pkg::FLAG_BYTE, 8'h5D,
        ahd_pkg::FLAG_BYTE,
        ahd_pkg::ESC_BYTE, ahd_pkg::ESC_BYTE, 8'h2D, ahd_pkg::LF_BYTE,
        ahd_pkg::FLAG_BYTE,
        8'h55, ahd_pkg::FLAG_BYTE
    };

    async_hdlc_deframer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_result(input logic [7:0] b, input logic last);
        ahd_pkg::res_t r;
        r.frame_byte    = b;
        r.last_of_frame = last;
        expected_bytes_q.insert(expected_bytes_q.size(), r);
    endtask

    task automatic clear_held();
        held0    = 8'h00;
        held1    = 8'h00;
        held_num = 0;
        emitted  = 1'b0;
    endtask

    // two bytes are kept back so a CR LF frame can still be dropped
    task automatic hold_in(input logic [7:0] b);
        if (held_num == 2)
        begin
            add_result(held0, 1'b0);
            held0   = held1;
            held1   = b;
            emitted = 1'b1;
        end
        else
        begin
            if (held_num == 0)
                held0 = b;
            else
                held1 = b;
            held_num++;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        ahd_pkg::mode_t m;
        logic           drop;
        m = rx_mode;
        if (b == ahd_pkg::FLAG_BYTE)
        begin
            if (m == ahd_pkg::MODE_NOSYNC || m == ahd_pkg::MODE_END)
            begin
                m = ahd_pkg::MODE_START;
                clear_held();
            end
            else if (m == ahd_pkg::MODE_DATA)
            begin
                drop = (held_num == 0) || (!emitted && held_num == 2 &&
                       held0 == ahd_pkg::CR_BYTE && held1 == ahd_pkg::LF_BYTE);
                if (drop)
                    m = ahd_pkg::MODE_START;
                else
                begin
                    if (held_num == 2)
                    begin
                        add_result(held0, 1'b0);
                        add_result(held1, 1'b1);
                    end
                    else
                        add_result(held0, 1'b1);
                    m = ahd_pkg::MODE_END;
                end
                clear_held();
            end
        end
        else if (b == ahd_pkg::ESC_BYTE)
            m = ahd_pkg::MODE_ESC;
        else if (m == ahd_pkg::MODE_START)
        begin
            clear_held();
            hold_in(b);
            m = ahd_pkg::MODE_DATA;
        end
        else if (m == ahd_pkg::MODE_DATA)
            hold_in(b);
        else if (m == ahd_pkg::MODE_ESC)
        begin
            hold_in(b ^ ahd_pkg::ESC_XOR);
            m = ahd_pkg::MODE_DATA;
        end
        rx_mode = m;
    endtask

    // driver: offers queued bytes, holds an item until full drops
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (push && !full)
            begin
                deframe_byte(rx_byte);
                bytes_sent++;
            end
            if (!push || !full)
            begin
                if (raw_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    push    <= 1'b1;
                    rx_byte <= raw_bytes_q.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: checks each popped transaction, then decides the next pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: frame_byte=%02h last_of_frame=%b",
                                 frame_byte, last_of_frame);
                end
                else
                begin
                    oldest = expected_bytes_q.pop_front();
                    if (frame_byte !== oldest.frame_byte ||
                        last_of_frame !== oldest.last_of_frame)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %02h/%b, got %02h/%b",
                                     oldest.frame_byte, oldest.last_of_frame,
                                     frame_byte, last_of_frame);
                    end
                end
            end
            if (long_hold && hold_cycles < HOLD_LEN)
            begin
                hold_cycles <= hold_cycles + 1;
                pop         <= 1'b0;
            end
            else
            begin
                if (!long_hold)
                    hold_cycles <= 0;
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        raw_bytes_q.insert(raw_bytes_q.size(), b);
        bytes_queued++;
    endtask

    // biased toward the codes the deframer reacts to
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return ahd_pkg::CR_BYTE;
            1:       return ahd_pkg::LF_BYTE;
            2:       return ahd_pkg::FLAG_BYTE;
            3:       return ahd_pkg::ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_payload(input logic [7:0] b);
        if (b == ahd_pkg::FLAG_BYTE || b == ahd_pkg::ESC_BYTE ||
            $urandom_range(0, 15) == 0)
        begin
            queue_byte(ahd_pkg::ESC_BYTE);
            queue_byte(b ^ ahd_pkg::ESC_XOR);
        end
        else
            queue_byte(b);
    endtask

    task automatic add_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 11);
        // a skipped opening flag shares the previous closing one
        if ($urandom_range(0, 7) != 0)
            queue_byte(ahd_pkg::FLAG_BYTE);
        if (kind == 0)
            queue_byte(ahd_pkg::FLAG_BYTE);
        else if (kind <= 2)
        begin
            queue_payload(ahd_pkg::CR_BYTE);
            queue_payload(ahd_pkg::LF_BYTE);
        end
        else if (kind == 3)
        begin
            queue_payload(ahd_pkg::CR_BYTE);
            queue_payload(ahd_pkg::LF_BYTE);
            len = $urandom_range(1, 3);
            repeat (len) queue_payload(pick_byte());
        end
        else if (kind == 4)
            queue_payload(ahd_pkg::CR_BYTE);
        else
        begin
            len = $urandom_range(1, 8);
            repeat (len) queue_payload(pick_byte());
        end
        // broken frame: escape right before the flag
        if ($urandom_range(0, 15) == 0)
            queue_byte(ahd_pkg::ESC_BYTE);
        queue_byte(ahd_pkg::FLAG_BYTE);
    endtask

    task automatic add_random(input int n);
        int stop_at;
        stop_at = bytes_queued + n;
        while (bytes_queued < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) queue_byte(pick_byte());
            else
                add_frame();
        end
    endtask

    task automatic wait_drained();
        while (bytes_sent != bytes_queued)
            @(posedge clk);
        while (expected_bytes_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 88;
        foreach (directed_bytes[i])
            queue_byte(directed_bytes[i]);
        wait_drained();

        add_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 36;
        add_random(PHASE_ITEMS / 2);
        wait_drained();
        add_random(PHASE_ITEMS / 2);
        wait_drained();

        // no idling; the result side stalls long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold = 1'b1;
        add_random(PHASE_ITEMS);
        wait_drained();
        long_hold = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_bytes_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ahd_pkg.sv
src/ahd_front.sv
src/ahd_engine.sv
src/ahd_resq.sv
src/async_hdlc_deframer.sv
test/async_hdlc_deframer_test.sv
